[design/precursor_theta_step_unit_assert.svh]
// ----------------------------------------------------------------------------
// Precursor theta step assertion macros
// Concurrent check shorthands clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PRECURSOR_THETA_STEP_UNIT_ASSERT_SVH
`define PRECURSOR_THETA_STEP_UNIT_ASSERT_SVH

// check a consequence in the same cycle
`define PTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("precursor theta step: same-cycle check failed");

// check a consequence in the next cycle
`define PTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("precursor theta step: next-cycle check failed");

`endif

[design/pts_pkg.sv]
// ----------------------------------------------------------------------------
// Precursor theta step package
// Shared command type, register codes and saturating add.
// ----------------------------------------------------------------------------
package pts_pkg;

  typedef enum logic {
    OP_ACCUM,
    OP_UPDATE
  } op_e;

  localparam logic [1:0] MODE_IMPLICIT = 2'd0;
  localparam logic [1:0] MODE_CRANK    = 2'd1;

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_DT   = 1'b1;

  localparam logic signed [63:0] S64_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  // classified operands: accumulate x=cs y=flux z=vf, update x=lambda y=yield z=prev
  typedef struct packed {
    op_e                op;
    logic               clear;
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
  } cmd_t;

  typedef struct packed {
    logic signed [63:0] val;
    logic               clip;
  } sat_t;

  function automatic sat_t sat_add(logic signed [63:0] a, logic signed [63:0] b);
    logic [64:0] sum;
    sat_t        r;
    sum = {a[63], a} + {b[63], b};
    r.clip = sum[64] != sum[63];
    if (r.clip) begin
      r.val = sum[64] ? S64_MIN : S64_MAX;
    end else begin
      r.val = signed'(sum[63:0]);
    end
    return r;
  endfunction

endpackage

[design/pts_front.sv]
// ----------------------------------------------------------------------------
// Precursor theta step front end
// Accepts input words, classifies them into commands, queues two of them.
// ----------------------------------------------------------------------------
module pts_front #(
  parameter int DATA_WIDTH = 48
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic                         action_i,
  input  logic                         cell_start_i,
  input  logic signed [DATA_WIDTH-1:0] cross_section_i,
  input  logic signed [DATA_WIDTH-1:0] flux_i,
  input  logic        [32:0]           volume_fraction_i,
  input  logic        [46:0]           decay_constant_i,
  input  logic        [32:0]           yield_fraction_i,
  input  logic signed [DATA_WIDTH-1:0] previous_concentration_i,
  output pts_pkg::cmd_t                cmd_o,
  output logic                         cmd_valid_o,
  input  logic                         cmd_pop_i
);

  pts_pkg::cmd_t cmd_in;
  pts_pkg::cmd_t queue_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  logic          do_push, do_pop;

  // classify the word into a command with 64-bit operands
  always_comb begin
    cmd_in.clear = cell_start_i;
    if (action_i) begin
      cmd_in.op = pts_pkg::OP_UPDATE;
      cmd_in.x  = signed'(64'(decay_constant_i));
      cmd_in.y  = signed'(64'(yield_fraction_i));
      cmd_in.z  = 64'(previous_concentration_i);
    end else begin
      cmd_in.op = pts_pkg::OP_ACCUM;
      cmd_in.x  = 64'(cross_section_i);
      cmd_in.y  = 64'(flux_i);
      cmd_in.z  = signed'(64'(volume_fraction_i));
    end
  end

  assign full_o      = cnt_q == 2'd2;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o       = queue_q[rp_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  // advance queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= !wp_q;
      if (do_pop)  rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  // hold queued commands
  always_ff @(posedge clk_i) begin
    if (do_push) queue_q[wp_q] <= cmd_in;
  end

endmodule

[design/pts_mul.sv]
// ----------------------------------------------------------------------------
// Precursor theta step multiplier
// Signed fixed point multiply from four 32x32 partial products, rounded
// half away from zero and clipped to 64-bit signed.
// ----------------------------------------------------------------------------
module pts_mul #(
  parameter int FRAC_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  output logic signed [63:0] res_o,
  output logic               clip_o,
  output logic               done_o
);

  logic               busy_q, done_q;
  logic [2:0]         cnt_q;
  logic [63:0]        ma_q, mb_q;
  logic               neg_q;
  logic [127:0]       acc_q;
  logic signed [63:0] res_q;
  logic               clip_q;

  logic [31:0]  ai, bi;
  logic [63:0]  pp;
  logic [127:0] pp_sh, rnd, sh;
  logic [63:0]  lim, magv;
  logic         over;

  // select and shift one partial product
  assign ai = cnt_q[0] ? ma_q[63:32] : ma_q[31:0];
  assign bi = cnt_q[1] ? mb_q[63:32] : mb_q[31:0];
  assign pp = 64'(ai) * 64'(bi);

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  // round, drop fraction bits, clip the magnitude
  assign rnd  = acc_q + (128'd1 << (FRAC_BITS - 1));
  assign sh   = rnd >> FRAC_BITS;
  assign lim  = neg_q ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
  assign over = (|sh[127:64]) || (sh[63:0] > lim);
  assign magv = over ? lim : sh[63:0];

  // sequence the partial products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 3'd0;
      end else if (busy_q) begin
        if (cnt_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 3'd1;
        end
      end
    end
  end

  // hold operands and the running sum
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q  <= a_i[63] ? 64'd0 - a_i : a_i;
      mb_q  <= b_i[63] ? 64'd0 - b_i : b_i;
      neg_q <= a_i[63] != b_i[63];
      acc_q <= 128'd0;
    end else if (busy_q) begin
      if (cnt_q == 3'd4) begin
        res_q  <= signed'(neg_q ? 64'd0 - magv : magv);
        clip_q <= over;
      end else begin
        acc_q <= acc_q + pp_sh;
      end
    end
  end

  assign res_o  = res_q;
  assign clip_o = clip_q;
  assign done_o = done_q;

endmodule

[design/pts_div.sv]
// ----------------------------------------------------------------------------
// Precursor theta step divider
// Restoring 128 by 64 bit division, one quotient bit a cycle, then a
// round-to-nearest step.
// ----------------------------------------------------------------------------
module pts_div (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] num_i,
  input  logic [63:0]  den_i,
  output logic [63:0]  quo_o,
  output logic         big_o,
  output logic         done_o
);

  logic         busy_q, round_q, done_q;
  logic [6:0]   cnt_q;
  logic [127:0] num_q, quo_q;
  logic [63:0]  rem_q, den_q;
  logic [63:0]  quo_r;
  logic         big_r;

  logic [64:0]  rem2, diff;
  logic         ge, up;
  logic [127:0] qr;

  // one restoring step
  assign rem2 = {rem_q, num_q[127]};
  assign diff = rem2 - {1'b0, den_q};
  assign ge   = rem2 >= {1'b0, den_q};

  // round to nearest, ties up
  assign up = rem_q >= (den_q - rem_q);
  assign qr = quo_q + 128'(up);

  // sequence the steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      round_q <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= 7'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        round_q <= 1'b0;
        cnt_q   <= 7'd0;
      end else if (busy_q) begin
        if (round_q) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'd127) round_q <= 1'b1;
        end
      end
    end
  end

  // hold remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= 64'd0;
      quo_q <= 128'd0;
    end else if (busy_q) begin
      if (round_q) begin
        quo_r <= qr[63:0];
        big_r <= |qr[127:64];
      end else begin
        num_q <= {num_q[126:0], 1'b0};
        rem_q <= ge ? diff[63:0] : rem2[63:0];
        quo_q <= {quo_q[126:0], ge};
      end
    end
  end

  assign quo_o  = quo_r;
  assign big_o  = big_r;
  assign done_o = done_q;

endmodule

[design/pts_back.sv]
// ----------------------------------------------------------------------------
// Precursor theta step back end
// Sequences fission accumulation and the theta update over the shared
// multiplier and divider, and queues two results.
// ----------------------------------------------------------------------------
module pts_back #(
  parameter int FRAC_BITS  = 32,
  parameter int DATA_WIDTH = 48
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pts_pkg::cmd_t                cmd_i,
  input  logic                         cmd_valid_i,
  output logic                         cmd_pop_o,
  input  logic [1:0]                   mode_i,
  input  logic [46:0]                  dt_i,
  output logic signed [DATA_WIDTH-1:0] res_o,
  output logic                         sat_o,
  output logic                         empty_o,
  input  logic                         pop_i
);

  localparam logic signed [63:0] ONE_Q    = signed'(64'd1 << FRAC_BITS);
  localparam logic signed [63:0] THETA_CN = ONE_Q / 2;
  localparam logic signed [63:0] THETA_07 = (64'sd7 * ONE_Q + 64'sd5) / 64'sd10;
  localparam logic signed [63:0] HI_LIM   =
    signed'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
  localparam logic signed [63:0] LO_LIM   = -HI_LIM - 64'sd1;

  typedef enum logic [3:0] {
    S_IDLE, S_A_MUL1, S_A_MUL2, S_U_EFF, S_U_DEN, S_U_COEF,
    S_U_S1, S_U_S2, S_U_VAL, S_U_M, S_U_RES
  } state_e;

  state_e             state_q;
  logic               issued_q;
  pts_pkg::cmd_t      cur_q;
  logic signed [63:0] acc_q, p_q, eff_q, den_q, coeff_q, s_q, val_q, t_q;
  logic               clip_q;

  logic signed [63:0] theta, ma, mb, mres;
  logic               mstart, mclip, mdone;
  logic [127:0]       dnum;
  logic [63:0]        dden, dquo, tmag, dlim, rmag;
  logic               dstart, dbig, ddone, dover;
  logic signed [63:0] rfull;
  logic               rclip;
  pts_pkg::sat_t      sa_acc, sa_den, sa_s, sa_t;
  logic               take, out_push, out_pop;

  logic signed [DATA_WIDTH-1:0] ores_q [2];
  logic                         osat_q [2];
  logic                         owp_q, orp_q;
  logic [1:0]                   ocnt_q;

  // theta by stepping mode
  always_comb begin
    case (mode_i)
      pts_pkg::MODE_IMPLICIT: theta = ONE_Q;
      pts_pkg::MODE_CRANK:    theta = THETA_CN;
      default:                theta = THETA_07;
    endcase
  end

  // route multiplier operands
  always_comb begin
    case (state_q)
      S_A_MUL1: begin ma = cur_q.x;         mb = cur_q.y;                end
      S_A_MUL2: begin ma = p_q;             mb = cur_q.z;                end
      S_U_EFF:  begin ma = theta;           mb = signed'(64'(dt_i));     end
      S_U_DEN:  begin ma = eff_q;           mb = cur_q.x;                end
      S_U_S1:   begin ma = eff_q;           mb = cur_q.y;                end
      S_U_S2:   begin ma = s_q;             mb = acc_q;                  end
      S_U_VAL:  begin ma = coeff_q;         mb = s_q;                    end
      S_U_M:    begin ma = theta - ONE_Q;   mb = cur_q.z;                end
      default:  begin ma = 64'sd0;          mb = 64'sd0;                 end
    endcase
  end

  // route divider operands
  assign tmag = t_q[63] ? 64'd0 - t_q : t_q;
  always_comb begin
    if (state_q == S_U_RES) begin
      dnum = {64'd0, tmag} << FRAC_BITS;
      dden = theta;
    end else begin
      dnum = 128'd1 << (2 * FRAC_BITS);
      dden = den_q;
    end
  end

  assign mstart = !issued_q && (state_q == S_A_MUL1 || state_q == S_A_MUL2 ||
                  state_q == S_U_EFF || state_q == S_U_DEN || state_q == S_U_S1 ||
                  state_q == S_U_S2 || state_q == S_U_VAL || state_q == S_U_M);
  assign dstart = !issued_q && (state_q == S_U_COEF || state_q == S_U_RES);

  pts_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mstart),
    .a_i     (ma),
    .b_i     (mb),
    .res_o   (mres),
    .clip_o  (mclip),
    .done_o  (mdone)
  );

  pts_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dstart),
    .num_i   (dnum),
    .den_i   (dden),
    .quo_o   (dquo),
    .big_o   (dbig),
    .done_o  (ddone)
  );

  // saturating sums of each step
  assign sa_acc = pts_pkg::sat_add(cur_q.clear ? 64'sd0 : acc_q, mres);
  assign sa_den = pts_pkg::sat_add(mres, ONE_Q);
  assign sa_s   = pts_pkg::sat_add(cur_q.z, mres);
  assign sa_t   = pts_pkg::sat_add(val_q, mres);

  // signed final quotient, then clip to the data range
  assign dlim  = t_q[63] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
  assign dover = dbig || (dquo > dlim);
  assign rmag  = dover ? dlim : dquo;
  assign rfull = signed'(t_q[63] ? 64'd0 - rmag : rmag);
  assign rclip = (rfull > HI_LIM) || (rfull < LO_LIM);

  assign take      = state_q == S_IDLE && cmd_valid_i &&
                     (cmd_i.op == pts_pkg::OP_ACCUM || ocnt_q != 2'd2);
  assign cmd_pop_o = take;
  assign out_push  = state_q == S_U_RES && ddone;
  assign out_pop   = pop_i && !empty_o;

  // step the sequencer and its control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      issued_q <= 1'b0;
      acc_q    <= 64'sd0;
      owp_q    <= 1'b0;
      orp_q    <= 1'b0;
      ocnt_q   <= 2'd0;
    end else begin
      if (mstart || dstart) issued_q <= 1'b1;
      if (mdone || ddone)   issued_q <= 1'b0;
      case (state_q)
        S_IDLE:   if (take) begin
                    state_q <= (cmd_i.op == pts_pkg::OP_UPDATE) ? S_U_EFF : S_A_MUL1;
                  end
        S_A_MUL1: if (mdone) state_q <= S_A_MUL2;
        S_A_MUL2: if (mdone) begin
                    acc_q   <= sa_acc.val;
                    state_q <= S_IDLE;
                  end
        S_U_EFF:  if (mdone) state_q <= S_U_DEN;
        S_U_DEN:  if (mdone) state_q <= S_U_COEF;
        S_U_COEF: if (ddone) state_q <= S_U_S1;
        S_U_S1:   if (mdone) state_q <= S_U_S2;
        S_U_S2:   if (mdone) state_q <= S_U_VAL;
        S_U_VAL:  if (mdone) state_q <= S_U_M;
        S_U_M:    if (mdone) state_q <= S_U_RES;
        S_U_RES:  if (ddone) state_q <= S_IDLE;
        default:  state_q <= S_IDLE;
      endcase
      if (out_push) owp_q <= !owp_q;
      if (out_pop)  orp_q <= !orp_q;
      ocnt_q <= ocnt_q + 2'(out_push) - 2'(out_pop);
    end
  end

  // hold intermediate values and the clip flag
  always_ff @(posedge clk_i) begin
    if (take) begin
      cur_q  <= cmd_i;
      clip_q <= 1'b0;
    end
    case (state_q)
      S_A_MUL1: if (mdone) p_q <= mres;
      S_U_EFF:  if (mdone) begin eff_q <= mres; clip_q <= clip_q | mclip; end
      S_U_DEN:  if (mdone) begin
                  den_q  <= sa_den.val;
                  clip_q <= clip_q | mclip | sa_den.clip;
                end
      S_U_COEF: if (ddone) begin
                  coeff_q <= (dbig || dquo[63]) ? pts_pkg::S64_MAX : signed'(dquo);
                  clip_q  <= clip_q | dbig | dquo[63];
                end
      S_U_S1:   if (mdone) begin s_q <= mres; clip_q <= clip_q | mclip; end
      S_U_S2:   if (mdone) begin
                  s_q    <= sa_s.val;
                  clip_q <= clip_q | mclip | sa_s.clip;
                end
      S_U_VAL:  if (mdone) begin val_q <= mres; clip_q <= clip_q | mclip; end
      S_U_M:    if (mdone) begin
                  t_q    <= sa_t.val;
                  clip_q <= clip_q | mclip | sa_t.clip;
                end
      default:  ;
    endcase
    if (out_push) begin
      if (rfull > HI_LIM) begin
        ores_q[owp_q] <= HI_LIM[DATA_WIDTH-1:0];
      end else if (rfull < LO_LIM) begin
        ores_q[owp_q] <= LO_LIM[DATA_WIDTH-1:0];
      end else begin
        ores_q[owp_q] <= rfull[DATA_WIDTH-1:0];
      end
      osat_q[owp_q] <= clip_q | dover | rclip;
    end
  end

  assign empty_o = ocnt_q == 2'd0;
  assign res_o   = ores_q[orp_q];
  assign sat_o   = osat_q[orp_q];

endmodule

[design/precursor_theta_step_unit.sv]
// ----------------------------------------------------------------------------
// Precursor theta step unit
// Accumulates a cell's delayed fission rate and updates precursor
// concentrations by the theta method in signed fixed point.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  input     push / full        action .. previous_concentration
//  result    empty / pop        new_concentration, saturated
//  config    cfg_we_i           cfg_index_i, cfg_data_i
//
// A fission term takes two passes of the four-step multiplier. A
// precursor update takes six multiplier passes plus two 128-step
// divisions in the bit-serial divider.
// Reset clears the accumulator, the queues and sets theta 1, time step 1.0.
// full rises with two commands queued; results wait in a two-word queue
// and an update does not start while that queue is full.
module precursor_theta_step_unit #(
  parameter int FRAC_BITS  = 32,
  parameter int DATA_WIDTH = 48
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic                         action_i,
  input  logic                         cell_start_i,
  input  logic signed [DATA_WIDTH-1:0] cross_section_i,
  input  logic signed [DATA_WIDTH-1:0] flux_i,
  input  logic        [32:0]           volume_fraction_i,
  input  logic        [46:0]           decay_constant_i,
  input  logic        [32:0]           yield_fraction_i,
  input  logic signed [DATA_WIDTH-1:0] previous_concentration_i,
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic        [46:0]           cfg_data_i,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [DATA_WIDTH-1:0] new_concentration_o,
  output logic                         saturated_o
);

  `include "precursor_theta_step_unit_assert.svh"

  pts_pkg::cmd_t cmd;
  logic          cmd_valid, cmd_pop;
  logic [1:0]    mode_q;
  logic [46:0]   dt_q;

  // hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= pts_pkg::MODE_IMPLICIT;
      dt_q   <= 47'(64'd1 << FRAC_BITS);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pts_pkg::REG_MODE: mode_q <= cfg_data_i[1:0];
        pts_pkg::REG_DT:   dt_q   <= cfg_data_i;
        default:           ;
      endcase
    end
  end

  pts_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .push_i                   (push),
    .full_o                   (full),
    .action_i                 (action_i),
    .cell_start_i             (cell_start_i),
    .cross_section_i          (cross_section_i),
    .flux_i                   (flux_i),
    .volume_fraction_i        (volume_fraction_i),
    .decay_constant_i         (decay_constant_i),
    .yield_fraction_i         (yield_fraction_i),
    .previous_concentration_i (previous_concentration_i),
    .cmd_o                    (cmd),
    .cmd_valid_o              (cmd_valid),
    .cmd_pop_i                (cmd_pop)
  );

  pts_back #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .mode_i      (mode_q),
    .dt_i        (dt_q),
    .res_o       (new_concentration_o),
    .sat_o       (saturated_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

  // check queue hand-off and register hold
  `PTS_ASSERT_NOW(a_pop_needs_cmd, cmd_pop, cmd_valid)
  `PTS_ASSERT_NEXT(a_mode_holds, !cfg_we_i, $stable(mode_q))
  `PTS_ASSERT_NEXT(a_dt_holds, !cfg_we_i, $stable(dt_q))

endmodule

[tb/sv/conc_checker.sv]
// ----------------------------------------------------------------------------
// Precursor concentration checker
// Watches the input, result and register channels of the theta step unit,
// predicts each new concentration and compares it with the popped word.
// ----------------------------------------------------------------------------
module conc_checker #(
  parameter int FRAC_BITS  = 32,
  parameter int DATA_WIDTH = 48
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  input  logic                         full,
  input  logic                         action_i,
  input  logic                         cell_start_i,
  input  logic signed [DATA_WIDTH-1:0] cross_section_i,
  input  logic signed [DATA_WIDTH-1:0] flux_i,
  input  logic        [32:0]           volume_fraction_i,
  input  logic        [46:0]           decay_constant_i,
  input  logic        [32:0]           yield_fraction_i,
  input  logic signed [DATA_WIDTH-1:0] previous_concentration_i,
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic        [46:0]           cfg_data_i,
  input  logic                         empty,
  input  logic                         pop,
  input  logic signed [DATA_WIDTH-1:0] new_concentration_i,
  input  logic                         saturated_i,
  output int                           errors_o,
  output int                           pending_o,
  output int                           terms_o,
  output int                           updates_o,
  output int                           clipped_o
);

  localparam logic signed [63:0] ONE_Q   = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] TOP_S64 = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] BOT_S64 = {1'b1, 63'd0};

  typedef struct {
    logic signed [DATA_WIDTH-1:0] conc;
    logic                         sat;
  } conc_t;

  conc_t              conc_expected[$];
  logic signed [63:0] fission_sum;
  logic        [1:0]  mode_q;
  logic        [46:0] dt_q;
  bit                 clipped;

  function automatic logic [63:0] magn(logic signed [63:0] v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // clamp a magnitude into signed 64 bits, note any clipping
  function automatic logic signed [63:0] fit64(bit neg, logic [127:0] m);
    logic [127:0] lim;
    lim = neg ? (128'd1 << 63) : ((128'd1 << 63) - 128'd1);
    if (m > lim) begin
      clipped = 1'b1;
      m = lim;
    end
    return neg ? -$signed(m[63:0]) : $signed(m[63:0]);
  endfunction

  // fixed point product, rounded half away from zero
  function automatic logic signed [63:0] mul_q(logic signed [63:0] a, logic signed [63:0] b);
    logic [127:0] m;
    m = {64'd0, magn(a)} * {64'd0, magn(b)};
    m = (m + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return fit64((a < 0) != (b < 0), m);
  endfunction

  function automatic logic signed [63:0] add_sat(logic signed [63:0] a, logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      clipped = 1'b1;
      return s[64] ? BOT_S64 : TOP_S64;
    end
    return $signed(s[63:0]);
  endfunction

  // unsigned quotient rounded to nearest, ties up
  function automatic logic [127:0] div_near(logic [127:0] n, logic [63:0] d);
    logic [127:0] q, r, dd;
    dd = {64'd0, d};
    q = n / dd;
    r = n % dd;
    if (r >= dd - r) q = q + 128'd1;
    return q;
  endfunction

  function automatic logic signed [63:0] theta_of(logic [1:0] m);
    case (m)
      pts_pkg::MODE_IMPLICIT: return ONE_Q;
      pts_pkg::MODE_CRANK:    return ONE_Q / 2;
      default:                return (7 * ONE_Q + 5) / 10;
    endcase
  endfunction

  // new fission sum after one term
  function automatic logic signed [63:0] fission_add(logic signed [63:0] sum, logic clr,
                                                     logic signed [63:0] cs,
                                                     logic signed [63:0] fl,
                                                     logic signed [63:0] vf);
    logic signed [63:0] p;
    if (clr) sum = '0;
    p = mul_q(mul_q(cs, fl), vf);
    return add_sat(sum, p);
  endfunction

  // theta method precursor update against the current fission sum
  function automatic conc_t theta_update(logic signed [63:0] lam, logic signed [63:0] yld,
                                         logic signed [63:0] prev);
    logic signed [63:0] th, eff, den, coeff, s, val, t, res, hi;
    conc_t r;
    clipped = 1'b0;
    th    = theta_of(mode_q);
    eff   = mul_q(th, $signed({17'd0, dt_q}));
    den   = add_sat(mul_q(eff, lam), ONE_Q);
    coeff = fit64(1'b0, div_near(128'd1 << (2 * FRAC_BITS), den));
    s     = add_sat(prev, mul_q(mul_q(eff, yld), fission_sum));
    val   = mul_q(coeff, s);
    t     = add_sat(val, mul_q(th - ONE_Q, prev));
    res   = fit64(t < 0, div_near({64'd0, magn(t)} << FRAC_BITS, th));
    hi    = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
    if (res > hi) begin
      res = hi;
      clipped = 1'b1;
    end
    if (res < -hi - 1) begin
      res = -hi - 1;
      clipped = 1'b1;
    end
    r.conc = res[DATA_WIDTH-1:0];
    r.sat  = clipped;
    return r;
  endfunction

  assign pending_o = conc_expected.size();

  // track registers, predict accepted words, check popped words
  always @(posedge clk_i or negedge rst_ni) begin
    conc_t exp_w;
    if (!rst_ni) begin
      conc_expected.delete();
      fission_sum <= '0;
      mode_q      <= pts_pkg::MODE_IMPLICIT;
      dt_q        <= 47'd1 << FRAC_BITS;
      errors_o    <= 0;
      terms_o     <= 0;
      updates_o   <= 0;
      clipped_o   <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == pts_pkg::REG_MODE) mode_q <= cfg_data_i[1:0];
        else dt_q <= cfg_data_i;
      end
      if (push && !full) begin
        if (pts_pkg::op_e'(action_i) == pts_pkg::OP_ACCUM) begin
          fission_sum <= fission_add(fission_sum, cell_start_i, cross_section_i, flux_i,
                                     $signed({31'd0, volume_fraction_i}));
          terms_o <= terms_o + 1;
        end else begin
          exp_w = theta_update($signed({17'd0, decay_constant_i}),
                               $signed({31'd0, yield_fraction_i}), previous_concentration_i);
          conc_expected.push_back(exp_w);
          updates_o <= updates_o + 1;
          if (exp_w.sat) clipped_o <= clipped_o + 1;
        end
      end
      if (pop && !empty) begin
        if (conc_expected.size() == 0) begin
          errors_o <= errors_o + 1;
          $display("%0t: unexpected word new_concentration %0d saturated %0b", $time,
                   new_concentration_i, saturated_i);
        end else begin
          exp_w = conc_expected.pop_front();
          if (exp_w.conc !== new_concentration_i || exp_w.sat !== saturated_i) begin
            errors_o <= errors_o + 1;
            if (errors_o < 20)
              $display("%0t: mismatch new_concentration exp %0d act %0d, saturated exp %0b act %0b",
                       $time, exp_w.conc, new_concentration_i, exp_w.sat, saturated_i);
          end
        end
      end
    end
  end

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// Precursor theta step testbench
// Streams fission terms and precursor updates through several stepping
// modes and time steps with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb;

  localparam int          FRAC_BITS   = 32;
  localparam int          DATA_WIDTH  = 48;
  localparam int          PHASE_WORDS = 185;
  localparam int          STALL_LIMIT = 20000;
  localparam int          DRAIN_WAIT  = 60;
  localparam int          CHOKE_LEN   = 1500;
  localparam logic [1:0]  MODE_OTHER  = 2'd2;
  localparam logic [1:0]  MODE_SPARE  = 2'd3;
  localparam logic [47:0] Q_ONE       = 48'd1 << FRAC_BITS;
  localparam logic [47:0] S48_MAX     = {1'b0, {47{1'b1}}};
  localparam logic [47:0] S48_MIN     = {1'b1, 47'd0};
  localparam logic [46:0] U47_MAX     = {47{1'b1}};
  localparam logic [32:0] FRAC_ONE    = 33'd1 << FRAC_BITS;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         push;
  logic                         full;
  logic                         action_i;
  logic                         cell_start_i;
  logic signed [DATA_WIDTH-1:0] cross_section_i;
  logic signed [DATA_WIDTH-1:0] flux_i;
  logic        [32:0]           volume_fraction_i;
  logic        [46:0]           decay_constant_i;
  logic        [32:0]           yield_fraction_i;
  logic signed [DATA_WIDTH-1:0] previous_concentration_i;
  logic                         cfg_we_i;
  logic                         cfg_index_i;
  logic        [46:0]           cfg_data_i;
  logic                         empty;
  logic                         pop;
  logic signed [DATA_WIDTH-1:0] new_concentration_o;
  logic                         saturated_o;

  int errors, pending, terms, updates, clipped;
  int idle_cycles;
  int send_burst;
  int phases_run;
  bit choke_req;

  precursor_theta_step_unit #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) dut (.*);

  conc_checker #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) u_checker (
    .new_concentration_i(new_concentration_o),
    .saturated_i        (saturated_o),
    .errors_o           (errors),
    .pending_o          (pending),
    .terms_o            (terms),
    .updates_o          (updates),
    .clipped_o          (clipped),
    .*
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // draw a signed Q value: extremes, plus or minus one, small magnitudes or any pattern
  function automatic logic [47:0] rand_q48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       return S48_MAX;
      1:       return S48_MIN;
      2:       return $urandom_range(0, 1) ? Q_ONE : -Q_ONE;
      3, 4:    return w[47:0];
      default: return $urandom_range(0, 1) ? {13'd0, w[34:0]} : -{13'd0, w[34:0]};
    endcase
  endfunction

  function automatic logic [32:0] rand_frac();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return FRAC_ONE;
      default: return {1'b0, $urandom};
    endcase
  endfunction

  function automatic logic [46:0] rand_u47();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return U47_MAX;
      2, 3:    return w[46:0];
      default: return {12'd0, w[34:0]};
    endcase
  endfunction

  // idle gaps: mostly none, some short, a few long, with gap-free bursts
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer the driven word and hold it until accepted
  task automatic offer_word();
    int gap;
    if (send_burst > 0) begin
      send_burst--;
      gap = 0;
    end else begin
      gap = gap_len();
      if ($urandom_range(0, 49) == 0) send_burst = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push = 1'b1;
    forever begin
      @(posedge clk_i);
      if (!full) break;
    end
    @(negedge clk_i);
  endtask

  task automatic send_term(logic start, logic [47:0] cs, logic [47:0] fl, logic [32:0] vf);
    action_i          = pts_pkg::OP_ACCUM;
    cell_start_i      = start;
    cross_section_i   = cs;
    flux_i            = fl;
    volume_fraction_i = vf;
    decay_constant_i  = rand_u47();
    yield_fraction_i  = rand_frac();
    offer_word();
  endtask

  task automatic send_update(logic [46:0] lam, logic [32:0] yld, logic [47:0] prev);
    action_i                 = pts_pkg::OP_UPDATE;
    cell_start_i             = 1'($urandom_range(0, 1));
    decay_constant_i         = lam;
    yield_fraction_i         = yld;
    previous_concentration_i = prev;
    cross_section_i          = rand_q48();
    flux_i                   = rand_q48();
    volume_fraction_i        = rand_frac();
    offer_word();
  endtask

  // wait until every result is out and the last terms have settled
  task automatic drain();
    push = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [46:0] val);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // one phase of random cells: terms then updates, with some noise words
  task automatic random_phase();
    int sent, n;
    sent = 0;
    while (sent < PHASE_WORDS) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1))
          send_term(1'($urandom_range(0, 1)), rand_q48(), rand_q48(), rand_frac());
        else
          send_update(rand_u47(), rand_frac(), rand_q48());
        sent++;
      end else begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
          send_term(i == 0, rand_q48(), rand_q48(), rand_frac());
        sent += n;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
          send_update(rand_u47(), rand_frac(), rand_q48());
        sent += n;
      end
    end
  endtask

  // release the result side in its own rhythm, with one long hold-off
  initial begin
    int stall;
    int burst;
    stall = 0;
    burst = 0;
    pop   = 1'b0;
    forever begin
      @(negedge clk_i);
      if (choke_req) begin
        choke_req = 1'b0;
        pop = 1'b0;
        repeat (CHOKE_LEN) @(negedge clk_i);
      end
      if (burst > 0) begin
        burst--;
        pop = 1'b1;
      end else if (stall > 0) begin
        stall--;
        pop = 1'b0;
      end else begin
        stall = gap_len();
        if ($urandom_range(0, 39) == 0) burst = $urandom_range(20, 80);
        pop = (stall == 0);
      end
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [1:0]  mode_list[8];
    logic [46:0] dt_list[8];
    rst_ni                   = 1'b0;
    push                     = 1'b0;
    action_i                 = pts_pkg::OP_ACCUM;
    cell_start_i             = 1'b0;
    cross_section_i          = '0;
    flux_i                   = '0;
    volume_fraction_i        = '0;
    decay_constant_i         = '0;
    yield_fraction_i         = '0;
    previous_concentration_i = '0;
    cfg_we_i                 = 1'b0;
    cfg_index_i              = pts_pkg::REG_MODE;
    cfg_data_i               = '0;
    choke_req                = 1'b0;
    send_burst               = 0;
    phases_run               = 0;
    mode_list = '{pts_pkg::MODE_CRANK, MODE_OTHER, MODE_SPARE, pts_pkg::MODE_IMPLICIT,
                  pts_pkg::MODE_CRANK, MODE_OTHER, pts_pkg::MODE_IMPLICIT,
                  pts_pkg::MODE_CRANK};
    dt_list   = '{47'(Q_ONE), 47'd42949673, 47'd0, U47_MAX,
                  47'd1 << 31, 47'd0, 47'(Q_ONE), 47'd0};
    dt_list[5] = rand_u47();
    dt_list[7] = {15'd0, $urandom};
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed words at reset settings: extremes, clipping, ignored fields
    send_term(1'b1, Q_ONE, Q_ONE << 1, FRAC_ONE);
    send_update(47'd0, FRAC_ONE, '0);
    send_term(1'b0, S48_MAX, S48_MAX, FRAC_ONE);
    send_term(1'b0, S48_MAX, S48_MAX, FRAC_ONE);
    send_update(U47_MAX, FRAC_ONE, S48_MIN);
    send_update(47'd0, FRAC_ONE, S48_MAX);
    send_term(1'b1, S48_MIN, S48_MAX, FRAC_ONE);
    send_term(1'b0, S48_MIN, S48_MAX, FRAC_ONE);
    send_update(47'd0, FRAC_ONE, S48_MIN);
    send_update(U47_MAX, '0, S48_MAX);
    send_term(1'b1, Q_ONE >> 1, -(Q_ONE * 3), '0);
    send_term(1'b0, -Q_ONE, -Q_ONE, FRAC_ONE >> 1);
    send_update(47'd429496730, 33'd42949673, Q_ONE * 5);
    send_update(47'd0, '0, '0);
    send_term(1'b1, S48_MIN, S48_MIN, FRAC_ONE);
    send_update(47'd0, FRAC_ONE, -Q_ONE);
    send_term(1'b1, 48'd1, 48'd1, 33'd1);
    send_update(47'd1, 33'd1, 48'd1);
    random_phase();
    phases_run++;

    // settings sweep, including zero and full time steps and the spare mode
    foreach (mode_list[p]) begin
      drain();
      write_reg(pts_pkg::REG_MODE, {45'd0, mode_list[p]});
      write_reg(pts_pkg::REG_DT, dt_list[p]);
      if (p == 2) choke_req = 1'b1;
      random_phase();
      phases_run++;
    end

    push = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    $display("Covered %0d fission terms and %0d precursor updates (%0d clipped)",
             terms, updates, clipped);
    $display("over %0d register settings of stepping mode and time step", phases_run);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/pts_pkg.sv
design/pts_front.sv
design/pts_mul.sv
design/pts_div.sv
design/pts_back.sv
design/precursor_theta_step_unit.sv
tb/sv/conc_checker.sv
tb/sv/tb.sv
